// File: rtl/fdts_pkg.sv
// Shared types and constants of the dual timer status block.
// Used by the top level, fdts_req_stage and fdts_timer_core; no dependencies of its own.
`default_nettype none

package fdts_pkg;

   // Beat kinds carried on tuser
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Register addresses
   localparam logic [7:0] ADDR_PRESET_ONE = 8'h02;
   localparam logic [7:0] ADDR_PRESET_TWO = 8'h03;
   localparam logic [7:0] ADDR_CONTROL    = 8'h04;

   // Control byte bit positions
   localparam int CTRL_CLEAR_BIT    = 7;
   localparam int CTRL_MASK_ONE_BIT = 6;
   localparam int CTRL_MASK_TWO_BIT = 5;
   localparam int CTRL_RUN_TWO_BIT  = 1;
   localparam int CTRL_RUN_ONE_BIT  = 0;

   // Flag register bit positions
   localparam int FLAG_IRQ_BIT = 2;
   localparam int FLAG_T1_BIT  = 1;
   localparam int FLAG_T2_BIT  = 0;

   // Timer period arithmetic: (256 - preset) * tick
   localparam int          PERIOD_W    = 17;
   localparam int          TIME_W      = 64;
   localparam logic [8:0]  PRESET_SPAN = 9'd256;
   localparam logic [PERIOD_W-1:0] TICK_ONE_US = 17'd80;
   localparam logic [PERIOD_W-1:0] TICK_TWO_US = 17'd320;

   // One request beat, unpacked
   typedef struct packed {
      logic              kind;
      logic [7:0]        reg_addr;
      logic [7:0]        wdata;
      logic [TIME_W-1:0] now_us;
   } req_beat_type;

   // Handshake between the request stage and the timer core
   typedef struct packed {
      logic valid;
      logic fire;
   } stage_ctl_type;

endpackage

`default_nettype wire

// File: rtl/fm_chip_dual_timer_status.sv
// Dual timer status block, top level: request register, timer core and
// response register. Uses fdts_pkg, fdts_req_stage, fdts_timer_core, fdts_rsp_stage.
//
// Usage: each request beat is a register write (req_tuser = 0) or a status
// read (req_tuser = 1), with address, data byte and microsecond timestamp in
// req_tdata. Writes to the preset and control registers give no response.
// Each read gives one response beat carrying the status byte.
// Path: a read goes from the request register through the core into the
// response register. Throughput is one beat per cycle unless a held response
// stalls a read; each timer's overflow check is a 64-bit subtract and two compares.
// Reset (synchronous, active high) clears presets, flags, run and mask bits,
// start stamps and both stage valid bits.
// Stall: a held response blocks only a read in the request register; writes
// still pass through. The request register refills as soon as its beat moves
// on, so writes are taken while a response waits, up to the first read.
`default_nettype none

module fm_chip_dual_timer_status (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [79:0] req_tdata,   // reg_addr[7:0], wdata[15:8], now_us[79:16]
   input  wire         req_tuser,   // kind: 0 write, 1 status read
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata    // status_byte[7:0]
);

   fdts_pkg::req_beat_type  beat;
   fdts_pkg::stage_ctl_type ctl;
   logic       beat_valid;
   logic       is_read;
   logic       room;
   logic [7:0] status_byte;

   // Consume a write always, a read only when the response register has room
   assign ctl.valid = beat_valid;
   assign ctl.fire  = beat_valid && (!is_read || room);

   fdts_req_stage u_req (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .in_kind     (req_tuser),
      .in_reg_addr (req_tdata[7:0]),
      .in_wdata    (req_tdata[15:8]),
      .in_now_us   (req_tdata[79:16]),
      .take        (ctl.fire),
      .beat        (beat),
      .beat_valid  (beat_valid)
   );

   fdts_timer_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .beat        (beat),
      .status_byte (status_byte),
      .is_read     (is_read)
   );

   fdts_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (ctl.fire && is_read),
      .load_data  (status_byte),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .room       (room)
   );

endmodule

`default_nettype wire

// File: rtl/fdts_req_stage.sv
// Request input register of the dual timer status block.
// Holds one accepted beat until the core consumes it; uses fdts_pkg.
`default_nettype none

module fdts_req_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire                  in_kind,
   input  wire  [7:0]           in_reg_addr,
   input  wire  [7:0]           in_wdata,
   input  wire  [63:0]          in_now_us,
   input  wire                  take,
   output fdts_pkg::req_beat_type beat,
   output logic                 beat_valid
);

   logic                    valid_ff;
   logic                    valid_in;
   fdts_pkg::req_beat_type  beat_ff;
   logic                    load;

   // Accept when empty or when the held beat leaves this cycle
   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff.kind     <= in_kind;
         beat_ff.reg_addr <= in_reg_addr;
         beat_ff.wdata    <= in_wdata;
         beat_ff.now_us   <= in_now_us;
      end
   end

   assign beat       = beat_ff;
   assign beat_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/fdts_timer_core.sv
// Timer state, register decode and overflow check of the dual timer block.
// Updates state once per consumed beat; uses fdts_pkg.
`default_nettype none

module fdts_timer_core (
   input  wire                    clock,
   input  wire                    reset,
   input  fdts_pkg::stage_ctl_type ctl,
   input  fdts_pkg::req_beat_type  beat,
   output logic [7:0]             status_byte,
   output logic                   is_read
);

   logic [7:0]  preset_one_ff, preset_one_in;
   logic [7:0]  preset_two_ff, preset_two_in;
   logic [2:0]  flag_ff, flag_in;
   logic        run_one_ff, run_one_in;
   logic        run_two_ff, run_two_in;
   logic        mask_one_ff, mask_one_in;
   logic        mask_two_ff, mask_two_in;
   logic [fdts_pkg::TIME_W-1:0] start_one_ff, start_one_in;
   logic [fdts_pkg::TIME_W-1:0] start_two_ff, start_two_in;

   logic [fdts_pkg::PERIOD_W-1:0] period_one, period_two;
   logic [fdts_pkg::TIME_W-1:0]   elapsed_one, elapsed_two;
   logic        hit_one, hit_two;
   logic [2:0]  flag_read;
   logic        go_one, go_two;

   // Periods from presets
   assign period_one = {8'd0, fdts_pkg::PRESET_SPAN - {1'b0, preset_one_ff}}
                       * fdts_pkg::TICK_ONE_US;
   assign period_two = {8'd0, fdts_pkg::PRESET_SPAN - {1'b0, preset_two_ff}}
                       * fdts_pkg::TICK_TWO_US;

   // Overflow check against the beat timestamp
   assign elapsed_one = beat.now_us - start_one_ff;
   assign elapsed_two = beat.now_us - start_two_ff;
   assign hit_one = run_one_ff && (beat.now_us >= start_one_ff)
                    && (elapsed_one >= {47'd0, period_one});
   assign hit_two = run_two_ff && (beat.now_us >= start_two_ff)
                    && (elapsed_two >= {47'd0, period_two});

   always_comb begin
      flag_read = flag_ff;
      if (hit_one) begin
         flag_read[fdts_pkg::FLAG_T1_BIT] = 1'b1;
         if (!mask_one_ff) flag_read[fdts_pkg::FLAG_IRQ_BIT] = 1'b1;
      end
      if (hit_two) begin
         flag_read[fdts_pkg::FLAG_T2_BIT] = 1'b1;
         if (!mask_two_ff) flag_read[fdts_pkg::FLAG_IRQ_BIT] = 1'b1;
      end
   end

   assign is_read     = (beat.kind == fdts_pkg::KIND_READ);
   assign status_byte = {flag_read, 5'd0};
   assign go_one      = beat.wdata[fdts_pkg::CTRL_RUN_ONE_BIT];
   assign go_two      = beat.wdata[fdts_pkg::CTRL_RUN_TWO_BIT];

   // Next state: decode writes, fold in read flags
   always_comb begin
      preset_one_in = preset_one_ff;
      preset_two_in = preset_two_ff;
      flag_in       = flag_ff;
      run_one_in    = run_one_ff;
      run_two_in    = run_two_ff;
      mask_one_in   = mask_one_ff;
      mask_two_in   = mask_two_ff;
      start_one_in  = start_one_ff;
      start_two_in  = start_two_ff;
      if (ctl.valid && ctl.fire) begin
         if (is_read) begin
            flag_in = flag_read;
         end else begin
            case (beat.reg_addr)
               fdts_pkg::ADDR_PRESET_ONE: begin
                  preset_one_in = beat.wdata;
               end
               fdts_pkg::ADDR_PRESET_TWO: begin
                  preset_two_in = beat.wdata;
               end
               fdts_pkg::ADDR_CONTROL: begin
                  if (beat.wdata[fdts_pkg::CTRL_CLEAR_BIT]) begin
                     flag_in = 3'd0;
                  end else begin
                     mask_one_in = beat.wdata[fdts_pkg::CTRL_MASK_ONE_BIT];
                     mask_two_in = beat.wdata[fdts_pkg::CTRL_MASK_TWO_BIT];
                     // Stamp start on a rising run bit only
                     if (go_one && !run_one_ff) start_one_in = beat.now_us;
                     if (go_two && !run_two_ff) start_two_in = beat.now_us;
                     run_one_in = go_one;
                     run_two_in = go_two;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_one_ff <= 8'd0;
         preset_two_ff <= 8'd0;
         flag_ff       <= 3'd0;
         run_one_ff    <= 1'b0;
         run_two_ff    <= 1'b0;
         mask_one_ff   <= 1'b0;
         mask_two_ff   <= 1'b0;
         start_one_ff  <= '0;
         start_two_ff  <= '0;
      end else begin
         preset_one_ff <= preset_one_in;
         preset_two_ff <= preset_two_in;
         flag_ff       <= flag_in;
         run_one_ff    <= run_one_in;
         run_two_ff    <= run_two_in;
         mask_one_ff   <= mask_one_in;
         mask_two_ff   <= mask_two_in;
         start_one_ff  <= start_one_in;
         start_two_ff  <= start_two_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fdts_rsp_stage.sv
// Response output register of the dual timer status block.
// Holds one status beat until the receiver takes it; uses no package.
`default_nettype none

module fdts_rsp_stage (
   input  wire        clock,
   input  wire        reset,
   input  wire        load,
   input  wire  [7:0] load_data,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       room
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // Room for a new beat when empty or draining this cycle
   assign room     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// File: rtl/fdts_checker.sv
// Port-level checks of the dual timer status block and their bind.
// Sees only the top-level ports of fm_chip_dual_timer_status.
`default_nettype none

module fdts_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata
);

   // Hold a stalled response beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   // Unused status bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] == 5'd0)
      else $error("reserved status bits set");

   // IRQ only comes with a timer overflow flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7] || rsp_tdata[6] || rsp_tdata[5])
      else $error("IRQ without overflow flag");

   // No response right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind fm_chip_dual_timer_status fdts_checker u_fdts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
